// File: rtl/core/button_gesture_detector_core_defines.svh
// Assertion macros for the button gesture detector core.
// Assertions are compiled out when SYNTHESIS is defined.
`ifndef BUTTON_GESTURE_DETECTOR_CORE_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked at every rising edge of clk_i, disabled while rst_ni is low.
`define BGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define BGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define BGD_ASSERT(lbl, prop, msg)
`define BGD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/core/bgd_pkg.sv
package bgd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned EventW   = 3;
  localparam int unsigned MsW      = 16;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESS   = 3'd1,
    ST_RELEASE = 3'd2,
    ST_COUNT   = 3'd3,
    ST_HOLD    = 3'd4,
    ST_HOLDEND = 3'd5
  } state_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE    = 3'd0,
    EV_COUNTED = 3'd1,
    EV_SINGLE  = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_MULTI   = 3'd4,
    EV_LSTART  = 3'd5,
    EV_LHELD   = 3'd6,
    EV_LSTOP   = 3'd7
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LOW  = 3'd0,
    CFG_DEBOUNCE    = 3'd1,
    CFG_MULTI_PRESS = 3'd2,
    CFG_LONG_PRESS  = 3'd3,
    CFG_MAX_PRESS   = 3'd4
  } cfg_idx_e;

  localparam logic            ActiveLowRst    = 1'b1;
  localparam logic [MsW-1:0]  DebounceRst     = 16'd50;
  localparam logic [MsW-1:0]  MultiPressRst   = 16'd400;
  localparam logic [MsW-1:0]  LongPressRst    = 16'd800;
  localparam logic [CountW-1:0] MaxPressRst   = 8'd1;

  typedef struct packed {
    logic              active_low;
    logic [MsW-1:0]    debounce_ms;
    logic [MsW-1:0]    multi_press_ms;
    logic [MsW-1:0]    long_press_ms;
    logic [CountW-1:0] max_press;
  } cfg_t;

  typedef struct packed {
    state_e            gesture;
    logic [CountW-1:0] press_cnt;
  } fsm_status_t;

endpackage

// File: rtl/core/bgd_intf.sv
interface bgd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          pin_level;
  logic [bgd_pkg::TimeW-1:0]     now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bgd_out_if;
  logic                          valid;
  logic                          ready;
  logic [bgd_pkg::EventW-1:0]    event_code;
  logic [bgd_pkg::CountW-1:0]    press_count;

  modport source (output valid, output event_code, output press_count, input ready);
  modport sink   (input valid, input event_code, input press_count, output ready);
endinterface

interface bgd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bgd_pkg::CfgIdxW-1:0]   index;
  logic [bgd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/button_gesture_detector_core.sv
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    pin_level, now_ms
// out_chan  out  valid/ready    event_code, press_count
// cfg       in   valid/ready    index, data (ready tied high)
//
// One poll per cycle sustained while out_chan is ready; each poll produces exactly one result.
// A poll goes through the input register, then gesture logic into the result register.
// Reset clears the gesture state and loads the register defaults.
// A stalled output holds the result register; the input register then fills
// and in_chan ready drops until the result is taken.
`include "button_gesture_detector_core_defines.svh"

module button_gesture_detector_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bgd_in_if.sink    in_chan_i,
  bgd_out_if.source out_chan_o,
  bgd_cfg_if.sink   cfg_i
);

  logic                          in_vld_q;
  logic                          in_pin_q;
  logic [bgd_pkg::TimeW-1:0]     in_now_q;

  logic                          out_vld_q;
  bgd_pkg::event_e               out_ev_q;
  logic [bgd_pkg::CountW-1:0]    out_cnt_q;

  logic                          advance;
  logic                          in_xfer;

  bgd_pkg::cfg_t                 cfg;
  bgd_pkg::event_e               fsm_ev;
  logic [bgd_pkg::CountW-1:0]    fsm_cnt;
  bgd_pkg::fsm_status_t          fsm_status;

  logic                          fsm_idle;
  logic                          fsm_end;

  assign advance         = in_vld_q && (!out_vld_q || out_chan_o.ready);
  assign in_chan_i.ready = !in_vld_q || advance;
  assign in_xfer         = in_chan_i.valid && in_chan_i.ready;

  assign out_chan_o.valid       = out_vld_q;
  assign out_chan_o.event_code  = out_ev_q;
  assign out_chan_o.press_count = out_cnt_q;

  bgd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bgd_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .pin_level_i   (in_pin_q),
    .now_ms_i      (in_now_q),
    .cfg_i         (cfg),
    .event_o       (fsm_ev),
    .press_count_o (fsm_cnt),
    .status_o      (fsm_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_pin_q <= in_chan_i.pin_level;
      in_now_q <= in_chan_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ev_q  <= fsm_ev;
      out_cnt_q <= fsm_cnt;
    end
  end

  assign fsm_idle = (fsm_status.gesture == bgd_pkg::ST_IDLE);
  assign fsm_end  = fsm_ev inside {bgd_pkg::EV_SINGLE, bgd_pkg::EV_DOUBLE,
                                   bgd_pkg::EV_MULTI, bgd_pkg::EV_LSTOP};

  // every poll that leaves the input register lands in the result register
  `BGD_ASSERT(a_advance_fills_out, advance |=> out_vld_q, "poll lost between stages")

  // idle is only ever entered with an empty press counter
  `BGD_ASSERT(a_idle_cnt_zero, fsm_idle |-> (fsm_status.press_cnt == '0), "idle with presses")

  // a gesture report always returns the machine to idle
  `BGD_ASSERT(a_report_clears, (advance && fsm_end) |=> fsm_idle, "gesture end kept state")

endmodule

// File: rtl/core/bgd_cfg_regs.sv
module bgd_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  bgd_cfg_if.sink          cfg_i,
  output bgd_pkg::cfg_t    cfg_o
);

  bgd_pkg::cfg_t cfg_q;
  bgd_pkg::cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bgd_pkg::CFG_ACTIVE_LOW:  cfg_d.active_low     = cfg_i.data[0];
        bgd_pkg::CFG_DEBOUNCE:    cfg_d.debounce_ms    = cfg_i.data[bgd_pkg::MsW-1:0];
        bgd_pkg::CFG_MULTI_PRESS: cfg_d.multi_press_ms = cfg_i.data[bgd_pkg::MsW-1:0];
        bgd_pkg::CFG_LONG_PRESS:  cfg_d.long_press_ms  = cfg_i.data[bgd_pkg::MsW-1:0];
        bgd_pkg::CFG_MAX_PRESS:   cfg_d.max_press      = cfg_i.data[bgd_pkg::CountW-1:0];
        default:                  cfg_d = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low     <= bgd_pkg::ActiveLowRst;
      cfg_q.debounce_ms    <= bgd_pkg::DebounceRst;
      cfg_q.multi_press_ms <= bgd_pkg::MultiPressRst;
      cfg_q.long_press_ms  <= bgd_pkg::LongPressRst;
      cfg_q.max_press      <= bgd_pkg::MaxPressRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/core/bgd_fsm.sv
module bgd_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          pin_level_i,
  input  logic [bgd_pkg::TimeW-1:0]     now_ms_i,
  input  bgd_pkg::cfg_t                 cfg_i,
  output bgd_pkg::event_e               event_o,
  output logic [bgd_pkg::CountW-1:0]    press_count_o,
  output bgd_pkg::fsm_status_t          status_o
);

  bgd_pkg::state_e                gst_q, gst_d;
  bgd_pkg::state_e                prev_q, prev_d;
  logic [bgd_pkg::TimeW-1:0]      start_q, start_d;
  logic [bgd_pkg::CountW-1:0]     cnt_q, cnt_d;

  logic                           active;
  logic                           clear;
  logic [bgd_pkg::TimeW-1:0]      elapsed;
  logic                           below_debounce;
  logic                           over_long;
  logic                           over_multi;

  assign active  = pin_level_i ^ cfg_i.active_low;
  assign elapsed = now_ms_i - start_q;

  assign below_debounce = elapsed < {{(bgd_pkg::TimeW-bgd_pkg::MsW){1'b0}}, cfg_i.debounce_ms};
  assign over_long      = elapsed > {{(bgd_pkg::TimeW-bgd_pkg::MsW){1'b0}}, cfg_i.long_press_ms};
  assign over_multi     = elapsed > {{(bgd_pkg::TimeW-bgd_pkg::MsW){1'b0}}, cfg_i.multi_press_ms};

  assign status_o.gesture   = gst_q;
  assign status_o.press_cnt = cnt_q;

  always_comb begin
    gst_d   = gst_q;
    prev_d  = prev_q;
    start_d = start_q;
    cnt_d   = cnt_q;
    event_o = bgd_pkg::EV_NONE;
    clear   = 1'b0;

    unique case (gst_q)
      bgd_pkg::ST_IDLE: begin
        if (active) begin
          prev_d  = gst_q;
          gst_d   = bgd_pkg::ST_PRESS;
          start_d = now_ms_i;
          cnt_d   = '0;
        end
      end
      bgd_pkg::ST_PRESS: begin
        if (!active) begin
          prev_d = gst_q;
          if (below_debounce) begin
            gst_d = prev_q;  // bounce, start time left as is
          end else begin
            gst_d   = bgd_pkg::ST_RELEASE;
            start_d = now_ms_i;
          end
        end else if (over_long) begin
          event_o = bgd_pkg::EV_LSTART;
          prev_d  = gst_q;
          gst_d   = bgd_pkg::ST_HOLD;
        end
      end
      bgd_pkg::ST_RELEASE: begin
        if (active && below_debounce) begin
          prev_d = gst_q;
          gst_d  = prev_q;
        end else if (!below_debounce) begin
          event_o = bgd_pkg::EV_COUNTED;
          cnt_d   = cnt_q + 1'b1;
          prev_d  = gst_q;
          gst_d   = bgd_pkg::ST_COUNT;
        end
      end
      bgd_pkg::ST_COUNT: begin
        if (active) begin
          prev_d  = gst_q;
          gst_d   = bgd_pkg::ST_PRESS;
          start_d = now_ms_i;
        end else if (over_multi || cnt_q == cfg_i.max_press) begin
          if (cnt_q == 8'd1) begin
            event_o = bgd_pkg::EV_SINGLE;
          end else if (cnt_q == 8'd2) begin
            event_o = bgd_pkg::EV_DOUBLE;
          end else begin
            event_o = bgd_pkg::EV_MULTI;
          end
          clear = 1'b1;
        end
      end
      bgd_pkg::ST_HOLD: begin
        if (!active) begin
          prev_d  = gst_q;
          gst_d   = bgd_pkg::ST_HOLDEND;
          start_d = now_ms_i;
        end else begin
          event_o = bgd_pkg::EV_LHELD;
        end
      end
      bgd_pkg::ST_HOLDEND: begin
        if (active && below_debounce) begin
          prev_d = gst_q;
          gst_d  = prev_q;
        end else if (!below_debounce) begin
          event_o = bgd_pkg::EV_LSTOP;
          clear   = 1'b1;
        end
      end
      default: begin
        prev_d = gst_q;
        gst_d  = bgd_pkg::ST_IDLE;
      end
    endcase

    // reported count is taken before the end-of-gesture clear
    press_count_o = cnt_d;

    if (clear) begin
      gst_d   = bgd_pkg::ST_IDLE;
      prev_d  = bgd_pkg::ST_IDLE;
      start_d = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gst_q   <= bgd_pkg::ST_IDLE;
      prev_q  <= bgd_pkg::ST_IDLE;
      start_q <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      gst_q   <= gst_d;
      prev_q  <= prev_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: test/tb_button_gesture_detector_core.sv
`timescale 1ns / 100ps

module tb_button_gesture_detector_core;
  import bgd_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct packed {
    logic              pin;
    logic [TimeW-1:0]  now;
  } poll_t;

  typedef struct packed {
    event_e            ev;
    logic [CountW-1:0] cnt;
  } gesture_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  bgd_in_if  in_if ();
  bgd_out_if out_if ();
  bgd_cfg_if cfg_if ();

  button_gesture_detector_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .cfg_i      (cfg_if)
  );

  poll_t           polls_pending[$];
  gesture_result_t events_expected[$];
  int              err_cnt = 0;
  int              polls_accepted = 0;
  logic            rx_stall = 1'b0;
  logic            in_gaps_on = 1'b1;
  logic            out_gaps_on = 1'b1;
  logic [TimeW-1:0] t_cur;

  // Predictor copy of the detector state and registers
  cfg_t              cfg_m;
  state_e            gst;
  state_e            pst;
  logic [TimeW-1:0]  t_start;
  logic [CountW-1:0] cnt;

  function automatic void move_to(input state_e next);
    pst = gst;
    gst = next;
  endfunction

  function automatic void clear_gesture();
    gst     = ST_IDLE;
    pst     = ST_IDLE;
    cnt     = '0;
    t_start = '0;
  endfunction

  function automatic gesture_result_t step_gesture(input logic pin, input logic [TimeW-1:0] now);
    gesture_result_t r;
    logic            act;
    logic [TimeW-1:0] el;
    act   = pin ^ cfg_m.active_low;
    el    = now - t_start;
    r.ev  = EV_NONE;
    r.cnt = cnt;
    case (gst)
      ST_IDLE: begin
        if (act) begin
          move_to(ST_PRESS);
          t_start = now;
          cnt     = '0;
        end
        r.cnt = cnt;
      end
      ST_PRESS: begin
        if (!act) begin
          // bounce: back to where we came from, start time kept
          if (el < cfg_m.debounce_ms) move_to(pst);
          else begin
            move_to(ST_RELEASE);
            t_start = now;
          end
        end else if (el > cfg_m.long_press_ms) begin
          r.ev = EV_LSTART;
          move_to(ST_HOLD);
        end
        r.cnt = cnt;
      end
      ST_RELEASE: begin
        if (act && el < cfg_m.debounce_ms) move_to(pst);
        else if (el >= cfg_m.debounce_ms) begin
          r.ev = EV_COUNTED;
          cnt  = cnt + 1'b1;
          move_to(ST_COUNT);
        end
        r.cnt = cnt;
      end
      ST_COUNT: begin
        r.cnt = cnt;
        if (act) begin
          move_to(ST_PRESS);
          t_start = now;
        end else if (el > cfg_m.multi_press_ms || cnt == cfg_m.max_press) begin
          if (cnt == 8'd1) r.ev = EV_SINGLE;
          else if (cnt == 8'd2) r.ev = EV_DOUBLE;
          else r.ev = EV_MULTI;
          clear_gesture();
        end
      end
      ST_HOLD: begin
        if (!act) begin
          move_to(ST_HOLDEND);
          t_start = now;
        end else begin
          r.ev = EV_LHELD;
        end
        r.cnt = cnt;
      end
      ST_HOLDEND: begin
        r.cnt = cnt;
        if (act && el < cfg_m.debounce_ms) move_to(pst);
        else if (el >= cfg_m.debounce_ms) begin
          r.ev = EV_LSTOP;
          clear_gesture();
        end
      end
      default: begin
        move_to(ST_IDLE);
        r.cnt = cnt;
      end
    endcase
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(input logic on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Input driver
  always @(posedge clk_i) begin : drive_polls
    poll_t p;
    int    gap;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        events_expected.push_back(step_gesture(in_if.pin_level, in_if.now_ms));
        polls_accepted++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          gap--;
        end else if (polls_pending.size() != 0) begin
          p = polls_pending.pop_front();
          in_if.valid     <= 1'b1;
          in_if.pin_level <= p.pin;
          in_if.now_ms    <= p.now;
          gap = pick_gap(in_gaps_on);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready generation
  always @(posedge clk_i) begin : take_results
    gesture_result_t want;
    int              gap;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (events_expected.size() == 0) begin
          $error("unexpected result: event_code %0d press_count %0d",
                 out_if.event_code, out_if.press_count);
          err_cnt++;
        end else begin
          want = events_expected.pop_front();
          if (out_if.event_code !== want.ev) begin
            $error("event_code: expected %0d, got %0d", want.ev, out_if.event_code);
            err_cnt++;
          end
          if (out_if.press_count !== want.cnt) begin
            $error("press_count: expected %0d, got %0d", want.cnt, out_if.press_count);
            err_cnt++;
          end
        end
      end
      if (rx_stall) out_if.ready <= 1'b0;
      else if (gap != 0) begin
        out_if.ready <= 1'b0;
        gap--;
      end else begin
        out_if.ready <= 1'b1;
        gap = pick_gap(out_gaps_on);
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering polls
  initial begin : rx_hold_off
    do @(posedge clk_i); while (polls_accepted < 60 || polls_pending.size() < 20);
    rx_stall <= 1'b1;
    repeat (150) @(posedge clk_i);
    rx_stall <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_button_gesture_detector_core: done, errors");
    $finish;
  end

  task automatic queue_poll(input logic pin, input logic [TimeW-1:0] now);
    poll_t p;
    p.pin = pin;
    p.now = now;
    polls_pending.push_back(p);
  endtask

  function automatic logic [TimeW-1:0] pick_dur(input logic [MsW-1:0] thr);
    logic [TimeW-1:0] th;
    th = thr;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, th);
      1: return (th == 0) ? 0 : th - 1;
      2: return th;
      3: return th + 1;
      4: return th + $urandom_range(1, 300);
      default: return (cfg_m.debounce_ms == 0) ? 0 : $urandom_range(0, cfg_m.debounce_ms - 1);
    endcase
  endfunction

  // Level held for dur ms, sampled by one to three polls
  task automatic add_segment(input logic active, input logic [TimeW-1:0] dur);
    int               k;
    logic [TimeW-1:0] step;
    k    = $urandom_range(1, 3);
    step = dur / k;
    for (int i = 0; i < k; i++) begin
      t_cur = t_cur + ((i == k - 1) ? dur - step * (k - 1) : step);
      queue_poll(active ^ cfg_m.active_low, t_cur);
    end
  endtask

  task automatic add_gestures(input int n_polls);
    int presses;
    t_cur = $urandom;
    while (polls_pending.size() < n_polls) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_poll($urandom_range(0, 1), $urandom);
      end else begin
        presses = $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0 && cfg_m.max_press < 12)
          presses = cfg_m.max_press + $urandom_range(0, 1);
        for (int i = 0; i < presses; i++) begin
          add_segment(1'b1, pick_dur(($urandom_range(0, 2) == 0) ? cfg_m.long_press_ms
                                                                  : cfg_m.debounce_ms));
          add_segment(1'b0, pick_dur(($urandom_range(0, 1) == 0) ? cfg_m.debounce_ms
                                                                  : cfg_m.multi_press_ms));
        end
        if ($urandom_range(0, 1) == 1)
          add_segment(1'b0, cfg_m.multi_press_ms + $urandom_range(1, 50));
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_ACTIVE_LOW:  cfg_m.active_low     = val[0];
      CFG_DEBOUNCE:    cfg_m.debounce_ms    = val;
      CFG_MULTI_PRESS: cfg_m.multi_press_ms = val;
      CFG_LONG_PRESS:  cfg_m.long_press_ms  = val;
      CFG_MAX_PRESS:   cfg_m.max_press      = val[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic al, input logic [MsW-1:0] db, input logic [MsW-1:0] mp,
                            input logic [MsW-1:0] lp, input logic [CfgDataW-1:0] mx);
    write_reg(CFG_ACTIVE_LOW, {15'h7fff, al});
    write_reg(CFG_DEBOUNCE, db);
    write_reg(CFG_MULTI_PRESS, mp);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_MAX_PRESS, mx);
  endtask

  // Sender pause: wait until every result is back, then let the pipe settle
  task automatic drain();
    do @(posedge clk_i);
    while (polls_pending.size() != 0 || in_if.valid || events_expected.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_gaps();
    in_gaps_on  <= ($urandom_range(0, 3) != 0);
    out_gaps_on <= ($urandom_range(0, 3) != 0);
  endtask

  initial begin : stimulus
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_ACTIVE_LOW;
    cfg_if.data     <= '0;
    cfg_m = '{ActiveLowRst, DebounceRst, MultiPressRst, LongPressRst, MaxPressRst};
    clear_gesture();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed polls under reset defaults (low level means pressed)
    queue_poll(1'b1, 32'd0);
    queue_poll(1'b0, 32'd100);
    queue_poll(1'b1, 32'd120);          // press bounce back to idle
    queue_poll(1'b0, 32'd130);
    queue_poll(1'b0, 32'd1000);         // long start
    queue_poll(1'b0, 32'd1001);         // long held
    queue_poll(1'b1, 32'd1010);
    queue_poll(1'b0, 32'd1020);         // hold-end bounce back to held
    queue_poll(1'b1, 32'd1030);
    queue_poll(1'b1, 32'd1080);         // long stop
    queue_poll(1'b0, 32'd2000);
    queue_poll(1'b1, 32'd2100);
    queue_poll(1'b0, 32'd2110);         // release bounce, start time not restored
    queue_poll(1'b1, 32'd2200);
    queue_poll(1'b1, 32'd2250);         // press counted
    queue_poll(1'b1, 32'd2251);         // single
    queue_poll(1'b0, 32'hffff_ff00);    // timer wraps during the press
    queue_poll(1'b1, 32'h0000_0010);
    queue_poll(1'b1, 32'h0000_0042);
    queue_poll(1'b1, 32'hffff_ffff);
    queue_poll(1'b0, 32'haaaa_5555);
    queue_poll(1'b1, 32'h5555_aaaa);
    queue_poll(1'b1, 32'h5555_aaaa);
    add_gestures(75);
    drain();

    set_config(1'b0, 16'd20, 16'd200, 16'd500, 16'd3);
    set_gaps();
    add_gestures(80);
    drain();

    // all windows zero, largest press count
    set_config(1'b1, 16'd0, 16'd0, 16'd0, 16'hffff);
    set_gaps();
    add_gestures(70);
    drain();

    set_config(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'd2);
    set_gaps();
    add_gestures(70);
    drain();

    // max_press of zero (upper data bits dropped), plus a write to an unused index
    set_config(1'b1, 16'd10, 16'd100, 16'd300, 16'h0100);
    write_reg(CFG_IDX_UNUSED, 16'h0000);
    set_gaps();
    add_gestures(60);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      set_config($urandom_range(0, 1), $urandom_range(0, 100), $urandom_range(0, 600),
                 $urandom_range(0, 1000), $urandom_range(1, 8));
      set_gaps();
      add_gestures(60);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_button_gesture_detector_core: done, clean");
    end else begin
      $display("tb_button_gesture_detector_core: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bgd_pkg.sv
rtl/core/bgd_intf.sv
rtl/core/bgd_cfg_regs.sv
rtl/core/bgd_fsm.sv
rtl/core/button_gesture_detector_core.sv
test/tb_button_gesture_detector_core.sv
